// ===== sv/bfr_pkg.sv =====
// Shared types and constants for the bitmap font text renderer.
// Holds the op codes, register indexes and the glyph metrics entry. No dependencies.
`default_nettype none

package bfr_pkg;

  typedef enum logic [1:0] {
    OP_LOAD_METRICS = 2'd0,
    OP_LOAD_ROW     = 2'd1,
    OP_SET_CURSOR   = 2'd2,
    OP_DRAW         = 2'd3
  } op_t;

  localparam logic [1:0] REG_RED   = 2'd0;
  localparam logic [1:0] REG_GREEN = 2'd1;
  localparam logic [1:0] REG_BLUE  = 2'd2;

  localparam int SIZE_BITS = 5;

  // One glyph metrics entry. The valid bit lives in flip-flops outside the memory.
  typedef struct packed {
    logic [SIZE_BITS-1:0] w;
    logic [SIZE_BITS-1:0] h;
    logic [7:0]           ox;
    logic [7:0]           oy;
    logic [7:0]           ax;
    logic [7:0]           ay;
  } glyph_meta_t;

endpackage

`default_nettype wire

// ===== sv/bitmap_font_text_renderer.sv =====
// Bitmap font text renderer: glyph metrics and row memories, pen and row emitter.
// Depends on bfr_pkg for op codes, register indexes and the metrics entry type.
`default_nettype none

// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall  op, char_code, row_index, row_bits, box_*, ...
// out       output     out_valid/out_stall  row_x, row_y, pixel_mask, red, green, blue, last
// cfg       input      APB psel/penable     paddr, pwdata, prdata, pready
//
// Load and set-cursor words are taken in IDLE, which they never leave. A draw word reads the
// metrics memory when it is accepted, passes a lookup state, then emits one glyph row per
// cycle while the output is not stalled, paced by the single read port of the row memory.
// A missing glyph or a zero height finishes after the lookup cycle.
// Synchronous reset clears the pen, the metrics valid bits and the output valid, and sets
// every color register to 255. The row memory is never cleared.
// A stalled output holds its word and the emitter waits. The input stays stalled until the
// last row of a draw is in the output register, so loads may be taken while that row waits.

module bitmap_font_text_renderer #(
  parameter int CODE_COUNT = 256,
  parameter int MAX_ROWS   = 16,
  parameter int MAX_COLS   = 16
) (
  input  wire               clk,
  input  wire               rst,

  input  wire               in_valid,
  output logic              in_stall,
  input  wire        [1:0]  op,
  input  wire        [7:0]  char_code,
  input  wire        [3:0]  row_index,
  input  wire        [15:0] row_bits,
  input  wire        [4:0]  box_width,
  input  wire        [4:0]  box_height,
  input  wire signed [7:0]  offset_x,
  input  wire signed [7:0]  offset_y,
  input  wire signed [7:0]  advance_x,
  input  wire signed [7:0]  advance_y,
  input  wire signed [15:0] pen_x,
  input  wire signed [15:0] pen_y,

  output logic              out_valid,
  input  wire               out_stall,
  output logic signed [15:0] row_x,
  output logic signed [15:0] row_y,
  output logic       [15:0] pixel_mask,
  output logic       [7:0]  red,
  output logic       [7:0]  green,
  output logic       [7:0]  blue,
  output logic              last,

  input  wire               psel,
  input  wire               penable,
  input  wire               pwrite,
  input  wire        [3:0]  paddr,
  input  wire        [31:0] pwdata,
  output logic       [31:0] prdata,
  output logic              pready
);

  // Codes beyond 256 cannot be named by an 8-bit code, and rows beyond 16 by a 4-bit index.
  localparam int CODE_DEPTH = (CODE_COUNT < 256) ? CODE_COUNT : 256;
  localparam int ROW_DEPTH  = (MAX_ROWS < 16) ? MAX_ROWS : 16;
  localparam int CW         = $clog2(CODE_DEPTH);
  localparam int RW         = (ROW_DEPTH > 1) ? $clog2(ROW_DEPTH) : 1;
  localparam int RCW        = RW + 1;
  localparam int W_CAP      = (MAX_COLS < 16) ? MAX_COLS : 16;
  localparam int H_CAP      = ROW_DEPTH;
  localparam int ROWS_DEPTH = CODE_DEPTH << RW;

  typedef enum logic [1:0] {
    IDLE,
    LOOKUP,
    EMIT
  } state_t;

  state_t state;

  logic [7:0]  color_red;
  logic [7:0]  color_green;
  logic [7:0]  color_blue;
  logic [15:0] pos_x;
  logic [15:0] pos_y;

  bfr_pkg::glyph_meta_t meta_mem [CODE_DEPTH];
  bfr_pkg::glyph_meta_t meta_q;
  logic [CODE_DEPTH-1:0] meta_valid;
  logic                  hit;

  logic [15:0] rows_mem [ROWS_DEPTH];
  logic [15:0] row_q;

  logic [CW-1:0]  draw_code;
  logic [15:0]    x_q;
  logic [15:0]    y_q;
  logic [15:0]    mask_q;
  logic [4:0]     h_q;
  logic [RCW-1:0] row_cnt;
  logic [RCW-1:0] row_cnt_next;

  logic               in_acc;
  logic               cfg_wr;
  logic               code_ok;
  logic               row_ok;
  logic               slot_free;
  logic               last_row;
  logic               rd_en;
  logic [CW+RW-1:0]   rd_addr;
  logic [4:0]         w_sat;
  logic [4:0]         h_sat;
  bfr_pkg::op_t       op_code;
  bfr_pkg::glyph_meta_t meta_in;

  assign op_code   = bfr_pkg::op_t'(op);
  assign in_stall  = (state != IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign code_ok   = (32'(char_code) < CODE_COUNT);
  assign row_ok    = (32'(row_index) < MAX_ROWS);
  assign slot_free = !out_valid || !out_stall;
  assign last_row  = (5'(row_cnt) + 5'd1 == h_q);
  assign row_cnt_next = row_cnt + RCW'(1);

  // Box sizes saturate when the glyph is loaded, so row_y sees the capped height.
  assign w_sat = (box_width  > 5'(W_CAP)) ? 5'(W_CAP) : box_width;
  assign h_sat = (box_height > 5'(H_CAP)) ? 5'(H_CAP) : box_height;

  always_comb begin
    meta_in    = '0;
    meta_in.w  = w_sat;
    meta_in.h  = h_sat;
    meta_in.ox = offset_x;
    meta_in.oy = offset_y;
    meta_in.ax = advance_x;
    meta_in.ay = advance_y;
  end

  // Row 0 is fetched in the lookup cycle; each emitted row fetches the one after it.
  always_comb begin
    rd_en   = (state == LOOKUP) || ((state == EMIT) && slot_free);
    rd_addr = {draw_code, (state == LOOKUP) ? RW'(0) : row_cnt_next[RW-1:0]};
  end

  assign red   = color_red;
  assign green = color_green;
  assign blue  = color_blue;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[3:2])
      bfr_pkg::REG_RED:   prdata = {24'd0, color_red};
      bfr_pkg::REG_GREEN: prdata = {24'd0, color_green};
      bfr_pkg::REG_BLUE:  prdata = {24'd0, color_blue};
      default:            prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      color_red   <= 8'd255;
      color_green <= 8'd255;
      color_blue  <= 8'd255;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        bfr_pkg::REG_RED:   color_red   <= pwdata[7:0];
        bfr_pkg::REG_GREEN: color_green <= pwdata[7:0];
        bfr_pkg::REG_BLUE:  color_blue  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Glyph metrics memory: written by a metrics load, read when a draw word is accepted.
  always_ff @(posedge clk) begin
    if (in_acc && (op_code == bfr_pkg::OP_LOAD_METRICS) && code_ok) begin
      meta_mem[char_code[CW-1:0]] <= meta_in;
    end
    if (in_acc && (op_code == bfr_pkg::OP_DRAW)) begin
      meta_q <= meta_mem[char_code[CW-1:0]];
    end
  end

  // Glyph row memory. Writes only happen in IDLE and reads only during a draw,
  // so the two never touch the same entry in one cycle.
  always_ff @(posedge clk) begin
    if (in_acc && (op_code == bfr_pkg::OP_LOAD_ROW) && code_ok && row_ok) begin
      rows_mem[{char_code[CW-1:0], row_index[RW-1:0]}] <= row_bits;
    end
    if (rd_en) begin
      row_q <= rows_mem[rd_addr];
    end
  end

  // Sequencer: pen, metrics valid bits, draw registers and the output word.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      out_valid  <= 1'b0;
      pos_x      <= 16'd0;
      pos_y      <= 16'd0;
      meta_valid <= '0;
      hit        <= 1'b0;
      row_cnt    <= '0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (in_acc) begin
            unique case (op_code)
              bfr_pkg::OP_LOAD_METRICS: begin
                if (code_ok) begin
                  meta_valid[char_code[CW-1:0]] <= 1'b1;
                end
              end
              bfr_pkg::OP_LOAD_ROW: ;
              bfr_pkg::OP_SET_CURSOR: begin
                pos_x <= pen_x;
                pos_y <= pen_y;
              end
              bfr_pkg::OP_DRAW: begin
                hit       <= code_ok && meta_valid[char_code[CW-1:0]];
                draw_code <= char_code[CW-1:0];
                state     <= LOOKUP;
              end
              default: ;
            endcase
          end
        end
        LOOKUP: begin
          // A missing glyph leaves the pen alone; a zero-height glyph still moves it.
          if (hit) begin
            x_q      <= pos_x + {{8{meta_q.ox[7]}}, meta_q.ox};
            y_q      <= pos_y + {{8{meta_q.oy[7]}}, meta_q.oy} + {11'd0, meta_q.h}
                        - 16'd1;
            mask_q   <= ~(16'hFFFF >> meta_q.w);
            h_q      <= meta_q.h;
            row_cnt  <= '0;
            pos_x    <= pos_x + {{8{meta_q.ax[7]}}, meta_q.ax};
            pos_y    <= pos_y + {{8{meta_q.ay[7]}}, meta_q.ay};
            state    <= (meta_q.h != 5'd0) ? EMIT : IDLE;
          end else begin
            state <= IDLE;
          end
        end
        EMIT: begin
          if (slot_free) begin
            out_valid  <= 1'b1;
            row_x      <= x_q;
            row_y      <= y_q;
            pixel_mask <= row_q & mask_q;
            last       <= last_row;
            y_q        <= y_q - 16'd1;
            row_cnt    <= row_cnt_next;
            if (last_row) begin
              state <= IDLE;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  // The emitter never runs past the glyph height.
  assert property (@(posedge clk) disable iff (rst)
    (state == EMIT) |-> (5'(row_cnt) < h_q))
    else $error("row counter ran past glyph height");

  // A draw of a missing glyph must leave the pen where it is.
  assert property (@(posedge clk) disable iff (rst)
    (state == LOOKUP && !hit) |=> ($stable(pos_x) && $stable(pos_y) && state == IDLE))
    else $error("missing glyph moved the pen");

  // The word that carries last returns the sequencer to IDLE.
  assert property (@(posedge clk) disable iff (rst)
    (state == EMIT && slot_free && last_row) |=> (state == IDLE && out_valid && last))
    else $error("final row did not end the draw");
`endif

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for bitmap_font_text_renderer: loads glyphs, moves the pen and
// draws text, predicting every emitted glyph row and checking it field by field.
// Depends on bfr_pkg for the op codes and register indexes, and on the renderer RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CODES          = 256;
  localparam int ROWS_PER_GLYPH = 16;
  localparam int COLS_CAP       = 16;
  // The slowest correct run stays far below this. Every word may take a sender gap, a full
  // draw in the block and 16 rows that each wait out a receiver stall.
  localparam int CYCLE_LIMIT    = 400000;
  // A draw that emits nothing still occupies the block for its lookup state after acceptance.
  localparam int SETTLE_CYCLES  = 8;

  // One input word, with every field present whatever the op.
  typedef struct {
    bfr_pkg::op_t op;
    logic [7:0]  char_code;
    logic [3:0]  row_index;
    logic [15:0] row_bits;
    logic [4:0]  box_width;
    logic [4:0]  box_height;
    logic [7:0]  offset_x;
    logic [7:0]  offset_y;
    logic [7:0]  advance_x;
    logic [7:0]  advance_y;
    logic [15:0] pen_x;
    logic [15:0] pen_y;
  } font_word_t;

  // One emitted glyph row.
  typedef struct {
    logic [15:0] row_x;
    logic [15:0] row_y;
    logic [15:0] pixel_mask;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        last;
  } glyph_row_t;

  // The scoreboard keeps its own copy of the glyph store, the pen and the color. Each
  // accepted word updates that copy, and a draw queues the rows that the block must emit.
  class glyph_scoreboard;
    bit          loaded [CODES];
    logic [4:0]  width [CODES];
    logic [4:0]  height [CODES];
    logic [7:0]  box_dx [CODES];
    logic [7:0]  box_dy [CODES];
    logic [7:0]  step_dx [CODES];
    logic [7:0]  step_dy [CODES];
    logic [15:0] bitmap [CODES*ROWS_PER_GLYPH];
    logic [15:0] pen_col;
    logic [15:0] pen_line;
    logic [7:0]  tint [3];
    glyph_row_t  expected_rows [$];
    int          mismatches;

    function new();
      foreach (loaded[i]) loaded[i] = 1'b0;
      foreach (bitmap[i]) bitmap[i] = '0;
      foreach (tint[i]) tint[i] = 8'd255;
      pen_col    = '0;
      pen_line   = '0;
      mismatches = 0;
    endfunction

    static function logic [15:0] sext(logic [7:0] v);
      return {{8{v[7]}}, v};
    endfunction

    function void set_color(logic [1:0] index, logic [7:0] value);
      case (index)
        bfr_pkg::REG_RED:   tint[bfr_pkg::REG_RED]   = value;
        bfr_pkg::REG_GREEN: tint[bfr_pkg::REG_GREEN] = value;
        bfr_pkg::REG_BLUE:  tint[bfr_pkg::REG_BLUE]  = value;
        default: ;
      endcase
    endfunction

    function void note_word(font_word_t w);
      glyph_row_t  row;
      logic [15:0] col;
      logic [15:0] base;
      logic [15:0] mask;
      logic [4:0]  h;
      int          code;
      code = w.char_code;
      case (w.op)
        bfr_pkg::OP_LOAD_METRICS: begin
          // Oversized boxes saturate when they are stored.
          loaded[code]  = 1'b1;
          width[code]   = (w.box_width > COLS_CAP) ? 5'(COLS_CAP) : w.box_width;
          height[code]  = (w.box_height > ROWS_PER_GLYPH) ? 5'(ROWS_PER_GLYPH) : w.box_height;
          box_dx[code]  = w.offset_x;
          box_dy[code]  = w.offset_y;
          step_dx[code] = w.advance_x;
          step_dy[code] = w.advance_y;
        end
        bfr_pkg::OP_LOAD_ROW: bitmap[code*ROWS_PER_GLYPH + w.row_index] = w.row_bits;
        bfr_pkg::OP_SET_CURSOR: begin
          pen_col  = w.pen_x;
          pen_line = w.pen_y;
        end
        bfr_pkg::OP_DRAW: begin
          // A missing glyph leaves everything alone. A zero height still moves the pen.
          if (loaded[code]) begin
            h    = height[code];
            mask = ~(16'hFFFF >> width[code]);
            col  = pen_col + sext(box_dx[code]);
            base = pen_line + sext(box_dy[code]) + 16'(h) - 16'd1;
            for (int r = 0; r < h; r++) begin
              row.row_x      = col;
              row.row_y      = base - 16'(r);
              row.pixel_mask = bitmap[code*ROWS_PER_GLYPH + r] & mask;
              row.red        = tint[bfr_pkg::REG_RED];
              row.green      = tint[bfr_pkg::REG_GREEN];
              row.blue       = tint[bfr_pkg::REG_BLUE];
              row.last       = (r == h - 1);
              expected_rows.push_back(row);
            end
            pen_col  = pen_col + sext(step_dx[code]);
            pen_line = pen_line + sext(step_dy[code]);
          end
        end
        default: ;
      endcase
    endfunction

    function void compare(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
        mismatches++;
      end
    endfunction

    function void check_row(glyph_row_t got);
      glyph_row_t want;
      if (expected_rows.size() == 0) begin
        $display("%0t: unexpected row, expected none, actual x=%h y=%h mask=%h",
                 $time, got.row_x, got.row_y, got.pixel_mask);
        mismatches++;
        return;
      end
      want = expected_rows.pop_front();
      compare("row_x", want.row_x, got.row_x);
      compare("row_y", want.row_y, got.row_y);
      compare("pixel_mask", want.pixel_mask, got.pixel_mask);
      compare("red", want.red, got.red);
      compare("green", want.green, got.green);
      compare("blue", want.blue, got.blue);
      compare("last", want.last, got.last);
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic        [1:0]  op;
  logic        [7:0]  char_code;
  logic        [3:0]  row_index;
  logic        [15:0] row_bits;
  logic        [4:0]  box_width;
  logic        [4:0]  box_height;
  logic        [7:0]  offset_x;
  logic        [7:0]  offset_y;
  logic        [7:0]  advance_x;
  logic        [7:0]  advance_y;
  logic        [15:0] pen_x;
  logic        [15:0] pen_y;
  logic               out_valid;
  logic               out_stall;
  logic        [15:0] row_x;
  logic        [15:0] row_y;
  logic        [15:0] pixel_mask;
  logic        [7:0]  red;
  logic        [7:0]  green;
  logic        [7:0]  blue;
  logic               last;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic        [3:0]  paddr;
  logic        [31:0] pwdata;
  logic        [31:0] prdata;
  logic               pready;

  glyph_scoreboard board;

  // Rows of each glyph that have been loaded at least once. Drawing a row that was never
  // loaded is not allowed, so every draw first fills whatever its glyph still lacks.
  logic [15:0] rows_present [CODES];
  logic [7:0]  glyph_pool [16];
  int          words_sent = 0;
  int          cycle_count = 0;
  bit          sender_gaps = 1'b0;
  bit          receiver_stalls = 1'b0;

  bitmap_font_text_renderer dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .char_code  (char_code),
    .row_index  (row_index),
    .row_bits   (row_bits),
    .box_width  (box_width),
    .box_height (box_height),
    .offset_x   (offset_x),
    .offset_y   (offset_y),
    .advance_x  (advance_x),
    .advance_y  (advance_y),
    .pen_x      (pen_x),
    .pen_y      (pen_y),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .row_x      (row_x),
    .row_y      (row_y),
    .pixel_mask (pixel_mask),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .last       (last),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The receiver stalls in random bursts. Between bursts it often runs
  // free for a while, so rows are taken both back to back and with gaps.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (receiver_stalls && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Every row taken by the receiver is checked against the oldest queued row. Values are
  // sampled as they stood just before the edge.
  always @(posedge clk) begin
    glyph_row_t seen;
    if (!rst && out_valid && !out_stall) begin
      seen.row_x      = row_x;
      seen.row_y      = row_y;
      seen.pixel_mask = pixel_mask;
      seen.red        = red;
      seen.green      = green;
      seen.blue       = blue;
      seen.last       = last;
      board.check_row(seen);
    end
  end

  // A hung block ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d rows outstanding", $time, board.expected_rows.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Fields that the op does not use get random values, since the block must ignore them.
  function automatic font_word_t random_word(bfr_pkg::op_t kind);
    font_word_t w;
    w.op         = kind;
    w.char_code  = 8'($urandom);
    w.row_index  = 4'($urandom);
    w.row_bits   = 16'($urandom);
    w.box_width  = 5'($urandom);
    w.box_height = 5'($urandom);
    w.offset_x   = 8'($urandom);
    w.offset_y   = 8'($urandom);
    w.advance_x  = 8'($urandom);
    w.advance_y  = 8'($urandom);
    w.pen_x      = 16'($urandom);
    w.pen_y      = 16'($urandom);
    return w;
  endfunction

  // Presents one word and holds it until the block takes it. The sender sometimes drops
  // valid for a random burst first.
  task automatic send_word(font_word_t w);
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    op         <= w.op;
    char_code  <= w.char_code;
    row_index  <= w.row_index;
    row_bits   <= w.row_bits;
    box_width  <= w.box_width;
    box_height <= w.box_height;
    offset_x   <= w.offset_x;
    offset_y   <= w.offset_y;
    advance_x  <= w.advance_x;
    advance_y  <= w.advance_y;
    pen_x      <= w.pen_x;
    pen_y      <= w.pen_y;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_word(w);
    if (w.op == bfr_pkg::OP_LOAD_ROW) rows_present[w.char_code][w.row_index] = 1'b1;
    words_sent++;
  endtask

  task automatic load_metrics(logic [7:0] code, logic [4:0] bw, logic [4:0] bh,
                              logic [7:0] ox, logic [7:0] oy, logic [7:0] ax,
                              logic [7:0] ay);
    font_word_t w;
    w            = random_word(bfr_pkg::OP_LOAD_METRICS);
    w.char_code  = code;
    w.box_width  = bw;
    w.box_height = bh;
    w.offset_x   = ox;
    w.offset_y   = oy;
    w.advance_x  = ax;
    w.advance_y  = ay;
    send_word(w);
  endtask

  task automatic load_row(logic [7:0] code, logic [3:0] index, logic [15:0] bits);
    font_word_t w;
    w           = random_word(bfr_pkg::OP_LOAD_ROW);
    w.char_code = code;
    w.row_index = index;
    w.row_bits  = bits;
    send_word(w);
  endtask

  task automatic set_pen(logic [15:0] x, logic [15:0] y);
    font_word_t w;
    w       = random_word(bfr_pkg::OP_SET_CURSOR);
    w.pen_x = x;
    w.pen_y = y;
    send_word(w);
  endtask

  // Draws one character. Rows that its glyph would read but that were never loaded get
  // random content first.
  task automatic draw_glyph(logic [7:0] code);
    font_word_t w;
    if (board.loaded[code]) begin
      for (int r = 0; r < board.height[code]; r++) begin
        if (!rows_present[code][r]) load_row(code, 4'(r), 16'($urandom));
      end
    end
    w           = random_word(bfr_pkg::OP_DRAW);
    w.char_code = code;
    send_word(w);
  endtask

  // A complete glyph definition: metrics, then every row it uses, bottom row first. Most
  // boxes are small. Some are wider or taller than the store holds.
  task automatic define_glyph(logic [7:0] code);
    logic [4:0] bw;
    logic [4:0] bh;
    int         rows;
    bw = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(17, 31)) : 5'($urandom_range(0, 16));
    bh = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(1, 6));
    load_metrics(code, bw, bh, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    rows = (bh > ROWS_PER_GLYPH) ? ROWS_PER_GLYPH : int'(bh);
    for (int r = rows - 1; r >= 0; r--) load_row(code, 4'(r), 16'($urandom));
  endtask

  // A short string of characters from the pool, sometimes from a new pen position.
  task automatic text_run();
    int n;
    n = $urandom_range(1, 5);
    if ($urandom_range(0, 1) == 0) set_pen(16'($urandom), 16'($urandom));
    repeat (n) draw_glyph(glyph_pool[$urandom_range(0, 15)]);
  endtask

  // Mostly well-formed glyph definitions followed by text. The rest is noise: draws of
  // arbitrary codes, which are usually missing glyphs, stray row loads and metrics loads
  // with every field random.
  task automatic random_phase(int count);
    int stop;
    stop = words_sent + count;
    while (words_sent < stop) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          define_glyph(glyph_pool[$urandom_range(0, 15)]);
          text_run();
        end
        4, 5: text_run();
        6: set_pen(16'($urandom), 16'($urandom));
        7: draw_glyph(8'($urandom));
        8: load_row(8'($urandom), 4'($urandom), 16'($urandom));
        default: load_metrics(8'($urandom), 5'($urandom), 5'($urandom), 8'($urandom),
                              8'($urandom), 8'($urandom), 8'($urandom));
      endcase
    end
  endtask

  // Stops sending and waits until every queued row has come back, then lets the block
  // finish any draw that emits nothing.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (board.expected_rows.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write with a setup and an access phase, followed by an idle phase on the
  // port. Only called while the block is idle.
  task automatic write_color(logic [1:0] index, logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= {24'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    board.set_color(index, value);
    @(posedge clk);
  endtask

  task automatic write_all_colors(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    write_color(bfr_pkg::REG_RED, r);
    write_color(bfr_pkg::REG_GREEN, g);
    write_color(bfr_pkg::REG_BLUE, b);
  endtask

  // Directed words, run with the reset color: the field extremes, each op, and the special
  // cases of the block.
  task automatic directed_words();
    // A draw before anything is loaded finds no glyph and must leave the pen alone.
    draw_glyph(8'h00);
    // The pen sits at the extremes so that the offsets and advances wrap.
    set_pen(16'h7FFF, 16'h8000);
    // Zero width: the row comes out with an empty mask.
    load_metrics(8'h00, 5'd0, 5'd1, 8'h00, 8'h00, 8'h01, 8'h00);
    load_row(8'h00, 4'd0, 16'hFFFF);
    draw_glyph(8'h00);
    // Zero height: nothing is emitted but the pen still moves.
    load_metrics(8'h80, 5'd7, 5'd0, 8'h7F, 8'h80, 8'h80, 8'h7F);
    draw_glyph(8'h80);
    // The second metrics load replaces the first and its width saturates.
    load_metrics(8'hFF, 5'd3, 5'd2, 8'h01, 8'h01, 8'h01, 8'h01);
    load_metrics(8'hFF, 5'd31, 5'd3, 8'h80, 8'h7F, 8'h7F, 8'h80);
    load_row(8'hFF, 4'd0, 16'h0000);
    load_row(8'hFF, 4'd1, 16'hFFFF);
    load_row(8'hFF, 4'd2, 16'h8001);
    // A second load of the same row wins over the first.
    load_row(8'hFF, 4'd1, 16'h5A5A);
    draw_glyph(8'hFF);
    set_pen(16'h8000, 16'h7FFF);
    draw_glyph(8'hFF);
    // The full height, with the top row index.
    load_metrics(8'h7F, 5'd16, 5'd16, 8'h00, 8'h00, 8'h10, 8'h00);
    draw_glyph(8'h7F);
  endtask

  initial begin
    board = new();
    foreach (rows_present[i]) rows_present[i] = '0;
    for (int i = 0; i < 16; i++) glyph_pool[i] = 8'($urandom);
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    op         <= bfr_pkg::OP_LOAD_METRICS;
    char_code  <= '0;
    row_index  <= '0;
    row_bits   <= '0;
    box_width  <= '0;
    box_height <= '0;
    offset_x   <= '0;
    offset_y   <= '0;
    advance_x  <= '0;
    advance_y  <= '0;
    pen_x      <= '0;
    pen_y      <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    sender_gaps     = 1'b1;
    receiver_stalls = 1'b1;

    directed_words();
    // The sender holds off here until every row is back before the color changes.
    wait_idle();

    write_all_colors(8'h00, 8'h00, 8'h00);
    random_phase(40);
    wait_idle();

    write_all_colors(8'hFF, 8'hFF, 8'hFF);
    random_phase(40);
    wait_idle();

    // The last stretch runs at full rate on both sides with a random color.
    write_all_colors(8'($urandom), 8'($urandom), 8'($urandom));
    sender_gaps     = 1'b0;
    receiver_stalls = 1'b0;
    random_phase(30);
    wait_idle();

    if (board.mismatches == 0 && board.expected_rows.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/bfr_pkg.sv
sv/bitmap_font_text_renderer.sv
tb/testbench.sv
